>>> design/glzw_pkg.sv
// ----------------------------------------------------------------------------
// glzw_pkg
// Shared types and constants for the GIF LZW decoder.
// ----------------------------------------------------------------------------
package glzw_pkg;

  localparam int MAX_CODE_BITS = 12;
  localparam int TABLE_DEPTH   = 1 << MAX_CODE_BITS;
  localparam int ADDR_W        = MAX_CODE_BITS;
  localparam int CODE_W        = MAX_CODE_BITS + 1;
  localparam int BUF_W         = MAX_CODE_BITS + 8;
  localparam int CNT_W         = $clog2(BUF_W + 1);
  localparam int WIDTH_W       = $clog2(MAX_CODE_BITS + 1);
  localparam int RES_CNT_W     = 7;
  localparam int MAX_PIX_RES   = 63;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 32;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_DATA  = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;

  localparam logic [1:0] KIND_PIXEL   = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_ILLEGAL = 2'd2;
  localparam logic [1:0] KIND_BADCNT  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CODE_SIZE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_PIXELS = 1'd1;

  typedef enum logic [1:0] {
    OP_START,
    OP_DATA,
    OP_END
  } op_e_t;

  typedef struct packed {
    op_e_t      op;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXTRACT,
    ST_RD_FP,
    ST_RD_FC,
    ST_ADD,
    ST_EXP,
    ST_WALK,
    ST_ROOT,
    ST_POP_RD,
    ST_POP_EM,
    ST_STATUS,
    ST_DONE
  } state_t;

endpackage

>>> design/glzw_if.sv
// ----------------------------------------------------------------------------
// glzw interfaces
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface glzw_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  modport source (output valid, req_type, data_byte, input ready);
  modport sink   (input valid, req_type, data_byte, output ready);
endinterface

interface glzw_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] pixel;
  logic       last;
  modport source (output valid, kind, pixel, last, input ready);
  modport sink   (input valid, kind, pixel, last, output ready);
endinterface

interface glzw_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [glzw_pkg::CFG_IDX_W-1:0]    index;
  logic [glzw_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/glzw_ram.sv
// ----------------------------------------------------------------------------
// glzw_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module glzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/glzw_front.sv
// ----------------------------------------------------------------------------
// glzw_front
// Takes request words, turns them into commands, queues two deep.
// ----------------------------------------------------------------------------
module glzw_front (
  input  logic              clk,
  input  logic              rst,
  glzw_req_if.sink          req,
  output glzw_pkg::cmd_t    cmd,
  output logic              cmd_valid,
  input  logic              cmd_ready
);
  import glzw_pkg::*;

  cmd_t       ent [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  logic       keep;
  cmd_t       cls;

  // reserved request code is taken and dropped
  always_comb begin
    keep     = 1'b1;
    cls.data = req.data_byte;
    cls.op   = OP_START;
    case (req.req_type)
      REQ_START: cls.op = OP_START;
      REQ_DATA:  cls.op = OP_DATA;
      REQ_END:   cls.op = OP_END;
      default:   keep = 1'b0;
    endcase
  end

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready && keep;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = ent[rptr];
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= cls;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

>>> design/glzw_engine.sv
// ----------------------------------------------------------------------------
// glzw_engine
// Code unpacking, string table upkeep, string expansion and result output.
// ----------------------------------------------------------------------------
module glzw_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  glzw_pkg::cmd_t                cmd,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  logic [3:0]                    min_code_size,
  input  logic [31:0]                   expected_pixels,
  glzw_rsp_if.source                    rsp
);
  import glzw_pkg::*;

  state_t                state, state_next;
  logic [3:0]            root, root_next;
  logic [WIDTH_W-1:0]    cw, cw_next;
  logic [CODE_W-1:0]     nf, nf_next;
  logic [ADDR_W-1:0]     prev, prev_next;
  logic                  prev_v, prev_v_next;
  logic [BUF_W-1:0]      bb, bb_next;
  logic [CNT_W-1:0]      bc, bc_next;
  logic [31:0]           pc, pc_next;
  logic                  fin, fin_next;
  logic [ADDR_W-1:0]     code, code_next;
  logic [ADDR_W-1:0]     c, c_next;
  logic [ADDR_W-1:0]     sp, sp_next;
  logic [7:0]            fp, fp_next;
  logic                  kwk, kwk_next;
  logic [RES_CNT_W-1:0]  n, n_next;
  logic [1:0]            st_kind, st_kind_next;
  logic [1:0]            h_kind, h_kind_next;
  logic [7:0]            h_pix, h_pix_next;
  logic                  h_v, h_v_next;
  logic                  ov, ov_next;
  logic [1:0]            o_kind, o_kind_next;
  logic [7:0]            o_pix, o_pix_next;
  logic                  o_last, o_last_next;

  logic [ADDR_W-1:0]     t_raddr, f_raddr, s_raddr, s_waddr;
  logic                  t_we, s_we;
  logic [ADDR_W-1:0]     p_rdata;
  logic [7:0]            x_rdata, f_rdata, s_rdata, x_wdata, s_wdata;

  logic [CODE_W-1:0]     clr;
  logic [BUF_W-1:0]      cmask;
  logic [CODE_W-1:0]     code_v;
  logic [CODE_W-1:0]     nf_inc;
  logic [ADDR_W-1:0]     sp_inc;
  logic [3:0]            msz;
  logic                  can_push;
  logic                  emit_req;
  logic                  emit_ok;
  logic [1:0]            emit_kind;
  logic [7:0]            emit_pix;
  logic                  pix_go;
  logic [31:0]           pc_sat;

  glzw_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_DEPTH)) u_prefix (
    .clk(clk), .we(t_we), .waddr(nf[ADDR_W-1:0]), .wdata(prev),
    .raddr(t_raddr), .rdata(p_rdata));
  glzw_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_suffix (
    .clk(clk), .we(t_we), .waddr(nf[ADDR_W-1:0]), .wdata(x_wdata),
    .raddr(t_raddr), .rdata(x_rdata));
  glzw_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_first (
    .clk(clk), .we(t_we), .waddr(nf[ADDR_W-1:0]), .wdata(fp),
    .raddr(f_raddr), .rdata(f_rdata));
  glzw_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata));

  assign clr        = CODE_W'(1) << root;
  assign cmask      = (BUF_W'(1) << cw) - BUF_W'(1);
  assign code_v     = CODE_W'(bb & cmask);
  assign can_push   = !ov || rsp.ready;
  assign emit_ok    = !h_v || can_push;
  assign pix_go     = (n >= RES_CNT_W'(MAX_PIX_RES)) || emit_ok;
  assign pc_sat     = (pc == '1) ? pc : pc + 32'd1;
  assign sp_inc     = sp + ADDR_W'(1);
  assign nf_inc     = nf + CODE_W'(1);

  assign rsp.valid  = ov;
  assign rsp.kind   = o_kind;
  assign rsp.pixel  = o_pix;
  assign rsp.last   = o_last;

  always_comb begin
    msz = min_code_size;
    if (msz < 4'd2) msz = 4'd2;
    if (msz > 4'd8) msz = 4'd8;
  end

  always_comb begin
    state_next   = state;
    root_next    = root;
    cw_next      = cw;
    nf_next      = nf;
    prev_next    = prev;
    prev_v_next  = prev_v;
    bb_next      = bb;
    bc_next      = bc;
    pc_next      = pc;
    fin_next     = fin;
    code_next    = code;
    c_next       = c;
    sp_next      = sp;
    fp_next      = fp;
    kwk_next     = kwk;
    n_next       = n;
    st_kind_next = st_kind;
    h_kind_next  = h_kind;
    h_pix_next   = h_pix;
    h_v_next     = h_v;
    ov_next      = (ov && rsp.ready) ? 1'b0 : ov;
    o_kind_next  = o_kind;
    o_pix_next   = o_pix;
    o_last_next  = o_last;
    cmd_ready    = 1'b0;
    t_raddr      = c;
    f_raddr      = prev;
    s_raddr      = sp - ADDR_W'(1);
    s_waddr      = sp;
    s_wdata      = x_rdata;
    s_we         = 1'b0;
    t_we         = 1'b0;
    x_wdata      = fp;
    emit_req     = 1'b0;
    emit_kind    = KIND_PIXEL;
    emit_pix     = 8'd0;

    case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          n_next = '0;
          case (cmd.op)
            OP_START: begin
              root_next   = msz;
              cw_next     = WIDTH_W'(msz) + WIDTH_W'(1);
              nf_next     = (CODE_W'(1) << msz) + CODE_W'(2);
              prev_v_next = 1'b0;
              prev_next   = '0;
              bb_next     = '0;
              bc_next     = '0;
              pc_next     = '0;
              fin_next    = 1'b0;
            end
            OP_DATA: begin
              if (!fin) begin
                bb_next    = bb | (BUF_W'(cmd.data) << bc);
                bc_next    = bc + CNT_W'(8);
                state_next = ST_EXTRACT;
              end
            end
            OP_END: begin
              if (!fin) begin
                fin_next     = 1'b1;
                st_kind_next = (pc == expected_pixels) ? KIND_DONE : KIND_BADCNT;
                state_next   = ST_STATUS;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EXTRACT: begin
        if (!fin && bc >= CNT_W'(cw)) begin
          bb_next   = bb >> cw;
          bc_next   = bc - CNT_W'(cw);
          code_next = code_v[ADDR_W-1:0];
          c_next    = code_v[ADDR_W-1:0];
          if (code_v == clr) begin
            cw_next     = WIDTH_W'(root) + WIDTH_W'(1);
            nf_next     = clr + CODE_W'(2);
            prev_v_next = 1'b0;
          end else if (code_v == clr + CODE_W'(1)) begin
            fin_next     = 1'b1;
            st_kind_next = (pc == expected_pixels) ? KIND_DONE : KIND_BADCNT;
            state_next   = ST_STATUS;
          end else if (code_v < nf) begin
            kwk_next   = 1'b0;
            state_next = (prev_v && nf < CODE_W'(TABLE_DEPTH)) ? ST_RD_FP : ST_EXP;
          end else if (code_v == nf && prev_v && nf < CODE_W'(TABLE_DEPTH)) begin
            kwk_next   = 1'b1;
            state_next = ST_RD_FP;
          end else begin
            fin_next     = 1'b1;
            st_kind_next = KIND_ILLEGAL;
            state_next   = ST_STATUS;
          end
        end else begin
          if (fin) begin
            bb_next = '0;
            bc_next = '0;
          end
          state_next = ST_DONE;
        end
      end
      ST_RD_FP: begin
        state_next = ST_RD_FC;
      end
      ST_RD_FC: begin
        fp_next    = (CODE_W'(prev) < clr) ? prev[7:0] : f_rdata;
        f_raddr    = code;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        // new entry: previous string plus first byte of this one
        t_we = 1'b1;
        if (kwk) begin
          x_wdata = fp;
        end else begin
          x_wdata = (CODE_W'(code) < clr) ? code[7:0] : f_rdata;
        end
        nf_next = nf_inc;
        if ((nf_inc & ((CODE_W'(1) << cw) - CODE_W'(1))) == '0 &&
            nf_inc < CODE_W'(TABLE_DEPTH)) begin
          cw_next = cw + WIDTH_W'(1);
        end
        state_next = ST_EXP;
      end
      ST_EXP: begin
        prev_next   = code;
        prev_v_next = 1'b1;
        sp_next     = '0;
        state_next  = (CODE_W'(c) < clr) ? ST_ROOT : ST_WALK;
      end
      ST_WALK: begin
        s_we    = 1'b1;
        sp_next = sp_inc;
        c_next  = p_rdata;
        t_raddr = p_rdata;
        if (!(CODE_W'(p_rdata) >= clr && sp_inc < ADDR_W'(TABLE_DEPTH - 1))) begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        emit_req = (n < RES_CNT_W'(MAX_PIX_RES));
        emit_pix = c[7:0];
        if (pix_go) begin
          pc_next    = pc_sat;
          state_next = (sp == '0) ? ST_EXTRACT : ST_POP_RD;
        end
      end
      ST_POP_RD: begin
        state_next = ST_POP_EM;
      end
      ST_POP_EM: begin
        emit_req = (n < RES_CNT_W'(MAX_PIX_RES));
        emit_pix = s_rdata;
        if (pix_go) begin
          pc_next    = pc_sat;
          sp_next    = sp - ADDR_W'(1);
          state_next = (sp == ADDR_W'(1)) ? ST_EXTRACT : ST_POP_RD;
        end
      end
      ST_STATUS: begin
        emit_req  = 1'b1;
        emit_kind = st_kind;
        if (emit_ok) state_next = ST_EXTRACT;
      end
      ST_DONE: begin
        // last held result of the word goes out with last set
        if (h_v) begin
          if (can_push) begin
            o_kind_next = h_kind;
            o_pix_next  = h_pix;
            o_last_next = 1'b1;
            ov_next     = 1'b1;
            h_v_next    = 1'b0;
            state_next  = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (emit_req && emit_ok) begin
      if (h_v) begin
        o_kind_next = h_kind;
        o_pix_next  = h_pix;
        o_last_next = 1'b0;
        ov_next     = 1'b1;
      end
      h_kind_next = emit_kind;
      h_pix_next  = emit_pix;
      h_v_next    = 1'b1;
      n_next      = n + RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    code    <= code_next;
    c       <= c_next;
    fp      <= fp_next;
    kwk     <= kwk_next;
    st_kind <= st_kind_next;
    h_kind  <= h_kind_next;
    h_pix   <= h_pix_next;
    o_kind  <= o_kind_next;
    o_pix   <= o_pix_next;
    o_last  <= o_last_next;
    prev    <= prev_next;
    if (rst) begin
      state  <= ST_IDLE;
      root   <= 4'd8;
      cw     <= WIDTH_W'(9);
      nf     <= CODE_W'(258);
      prev_v <= 1'b0;
      bb     <= '0;
      bc     <= '0;
      pc     <= '0;
      fin    <= 1'b0;
      sp     <= '0;
      n      <= '0;
      h_v    <= 1'b0;
      ov     <= 1'b0;
    end else begin
      state  <= state_next;
      root   <= root_next;
      cw     <= cw_next;
      nf     <= nf_next;
      prev_v <= prev_v_next;
      bb     <= bb_next;
      bc     <= bc_next;
      pc     <= pc_next;
      fin    <= fin_next;
      sp     <= sp_next;
      n      <= n_next;
      h_v    <= h_v_next;
      ov     <= ov_next;
    end
  end
endmodule

>>> design/gif_lzw_decoder.sv
// ----------------------------------------------------------------------------
// gif_lzw_decoder
// GIF LZW decompressor, variable code width up to 12 bits.
// ----------------------------------------------------------------------------
// Flow: a data word is accepted, then each code in it is unpacked, a table entry is
//   added, the expansion starts, the table is walked once per string byte past the
//   first, the first pixel goes out and further pixels are popped from the stack
//   (registered RAM reads); a final unpack check and the last result hand-off end it.
// Words are decoded one at a time; the front queues up to two more.
// Reset: synchronous; min code size 8, no clearing pass, tables read only where written.
module gif_lzw_decoder (
  input  logic       clk,
  input  logic       rst,
  glzw_req_if.sink   req,
  glzw_rsp_if.source rsp,
  glzw_cfg_if.sink   cfg
);
  import glzw_pkg::*;

  cmd_t        cmd;
  logic        cmd_valid;
  logic        cmd_ready;
  logic [3:0]  min_code_size;
  logic [31:0] expected_pixels;

  // config regs: always ready; min code size is sampled by the engine at start of image, expected pixels at its end
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_code_size   <= 4'd8;
      expected_pixels <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_MIN_CODE_SIZE:   min_code_size   <= cfg.data[3:0];
        CFG_EXPECTED_PIXELS: expected_pixels <= cfg.data;
        default: ;
      endcase
    end
  end

  // front: classify and queue request words
  glzw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  // back: code unpack, table, expansion, result register
  glzw_engine u_engine (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .min_code_size   (min_code_size),
    .expected_pixels (expected_pixels),
    .rsp             (rsp)
  );
endmodule
